@@ hdl/rtnp_pkg.sv @@
// rtnp_pkg: shared types, constants and lookup functions for the ring-tone note parser.
// Used by every file under hdl; depends on nothing.
`timescale 1ns / 1ps

package rtnp_pkg;

    // Field widths
    localparam int CHAR_W      = 8;
    localparam int DIV_W       = 8;   // note length divisor, saturates at 255
    localparam int DEF_DIV_W   = 7;
    localparam int OCT_W       = 4;
    localparam int WHOLE_W     = 18;
    localparam int FREQ_W      = 16;
    localparam int LEN_W       = 19;
    localparam int HZ_W        = 9;   // base plus sharp offset, at most 247
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    localparam int BASE_OCTAVE = 3;
    localparam int DIV_STEPS   = WHOLE_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LENGTH_DIV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OCTAVE_NUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_NOTE_MS      = 2'd2;

    // Reset values of the registers
    localparam logic [DEF_DIV_W-1:0] DEFAULT_LENGTH_DIV_RST = 7'd4;
    localparam logic [OCT_W-1:0]     DEFAULT_OCTAVE_NUM_RST = 4'd4;
    localparam logic [WHOLE_W-1:0]   WHOLE_NOTE_MS_RST      = 18'd3809;

    // Characters
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DUR    = 3'd1,
        PH_LETTER = 3'd2,
        PH_SHARP  = 3'd3,
        PH_DOT    = 3'd4,
        PH_OCT    = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DIV,
        SEQ_FIN
    } seq_state_t;

    typedef enum logic [3:0] {
        NOTE_P    = 4'd0,
        NOTE_C    = 4'd1,
        NOTE_D    = 4'd2,
        NOTE_E    = 4'd3,
        NOTE_F    = 4'd4,
        NOTE_G    = 4'd5,
        NOTE_A    = 4'd6,
        NOTE_B    = 4'd7,
        NOTE_NONE = 4'd8
    } note_code_t;

    // Resolved note handed from the parser to the sequencer
    typedef struct packed {
        logic [2:0]       code;
        logic             sharp;
        logic             dot;
        logic [OCT_W-1:0] octave;
        logic [DIV_W-1:0] divisor;   // never zero
    } note_req_t;

    function automatic note_code_t letter_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        note_code_t        code;
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
        unique case (lc)
            8'h70:   code = NOTE_P;
            8'h63:   code = NOTE_C;
            8'h64:   code = NOTE_D;
            8'h65:   code = NOTE_E;
            8'h66:   code = NOTE_F;
            8'h67:   code = NOTE_G;
            8'h61:   code = NOTE_A;
            8'h62:   code = NOTE_B;
            default: code = NOTE_NONE;
        endcase
        return code;
    endfunction

    // Frequency at the base octave, sharp offset included
    function automatic logic [HZ_W-1:0] note_hz(input logic [2:0] code, input logic sharp);
        logic [HZ_W-1:0] base;
        logic [HZ_W-1:0] ofs;
        unique case (code)
            3'd1:    begin base = 9'd131; ofs = 9'd8;  end
            3'd2:    begin base = 9'd147; ofs = 9'd9;  end
            3'd3:    begin base = 9'd165; ofs = 9'd0;  end
            3'd4:    begin base = 9'd175; ofs = 9'd10; end
            3'd5:    begin base = 9'd196; ofs = 9'd12; end
            3'd6:    begin base = 9'd220; ofs = 9'd13; end
            3'd7:    begin base = 9'd247; ofs = 9'd0;  end
            default: begin base = 9'd0;   ofs = 9'd0;  end
        endcase
        return sharp ? base + ofs : base;
    endfunction

endpackage

@@ hdl/rtnp_char_if.sv @@
// rtnp_char_if: character channel, one tune character per transfer.
// Depends on rtnp_pkg for widths.
`timescale 1ns / 1ps

interface rtnp_char_if;
    logic                         valid;
    logic                         ready;
    logic [rtnp_pkg::CHAR_W-1:0]  char_code;
    logic                         end_of_tune;

    modport source (output valid, output char_code, output end_of_tune, input ready);
    modport sink   (input valid, input char_code, input end_of_tune, output ready);
endinterface

@@ hdl/rtnp_note_if.sv @@
// rtnp_note_if: note channel, one parsed note per transfer.
// Depends on rtnp_pkg for widths.
`timescale 1ns / 1ps

interface rtnp_note_if;
    logic                         valid;
    logic                         ready;
    logic [rtnp_pkg::FREQ_W-1:0]  frequency_hz;
    logic [rtnp_pkg::LEN_W-1:0]   length_ms;
    logic                         rest_flag;
    logic [rtnp_pkg::OCT_W-1:0]   octave_used;

    modport source (output valid, output frequency_hz, output length_ms,
                    output rest_flag, output octave_used, input ready);
    modport sink   (input valid, input frequency_hz, input length_ms,
                    input rest_flag, input octave_used, output ready);
endinterface

@@ hdl/rtnp_parser.sv @@
// rtnp_parser: character-level note grammar; holds the partial note between characters.
// Depends on rtnp_pkg.
`timescale 1ns / 1ps

module rtnp_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic [rtnp_pkg::CHAR_W-1:0]         char_code,
    input  logic                                end_of_tune,
    input  logic [rtnp_pkg::DEF_DIV_W-1:0]      default_length_div,
    input  logic [rtnp_pkg::OCT_W-1:0]          default_octave_num,
    output logic                                fire,
    output rtnp_pkg::note_req_t                 note
);

    rtnp_pkg::phase_t                phase_reg,  phase_next;
    logic [rtnp_pkg::DIV_W-1:0]      accum_reg,  accum_next;
    logic [2:0]                      code_reg,   code_next;
    logic                            sharp_reg,  sharp_next;
    logic                            dot_reg,    dot_next;
    logic [rtnp_pkg::DIV_W-1:0]      len_div_reg, len_div_next;
    logic [rtnp_pkg::OCT_W-1:0]      octave_reg, octave_next;

    logic                            is_digit;
    logic [3:0]                      digit;
    rtnp_pkg::note_code_t            lc;
    logic [11:0]                     accum_sum;
    logic [7:0]                      oct_sum;
    logic                            drop;
    logic [rtnp_pkg::DIV_W-1:0]      div_pick;

    assign is_digit  = (char_code >= rtnp_pkg::CH_ZERO) && (char_code <= rtnp_pkg::CH_NINE);
    assign digit     = is_digit ? 4'(char_code - rtnp_pkg::CH_ZERO) : 4'd0;
    assign lc        = rtnp_pkg::letter_code(char_code);
    assign accum_sum = 12'(accum_reg) * 12'd10 + 12'(digit);
    assign oct_sum   = ((phase_reg == rtnp_pkg::PH_OCT) ? 8'(octave_reg) : 8'd0) * 8'd10
                       + 8'(digit);

    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        code_next    = code_reg;
        sharp_next   = sharp_reg;
        dot_next     = dot_reg;
        len_div_next = len_div_reg;
        octave_next  = octave_reg;
        fire         = 1'b0;
        drop         = 1'b0;

        priority if (char_code == rtnp_pkg::CH_COMMA)
        begin
            if (phase_reg >= rtnp_pkg::PH_LETTER)
                fire = 1'b1;
            else
                drop = 1'b1;
        end
        else if (phase_reg <= rtnp_pkg::PH_DUR)
        begin
            if (is_digit)
            begin
                accum_next = (accum_sum > 12'd255) ? 8'd255 : accum_sum[7:0];
                phase_next = rtnp_pkg::PH_DUR;
            end
            else if (lc != rtnp_pkg::NOTE_NONE)
            begin
                code_next    = lc[2:0];
                len_div_next = accum_reg;
                accum_next   = '0;
                phase_next   = rtnp_pkg::PH_LETTER;
            end
        end
        else if (char_code == rtnp_pkg::CH_SHARP && phase_reg == rtnp_pkg::PH_LETTER)
        begin
            sharp_next = 1'b1;
            phase_next = rtnp_pkg::PH_SHARP;
        end
        else if (char_code == rtnp_pkg::CH_DOT &&
                 (phase_reg == rtnp_pkg::PH_LETTER || phase_reg == rtnp_pkg::PH_SHARP))
        begin
            dot_next   = 1'b1;
            phase_next = rtnp_pkg::PH_DOT;
        end
        else if (char_code == rtnp_pkg::CH_DOT && phase_reg == rtnp_pkg::PH_OCT && !dot_reg)
        begin
            dot_next   = 1'b1;
            phase_next = rtnp_pkg::PH_DONE;
        end
        else if (is_digit && phase_reg >= rtnp_pkg::PH_LETTER && phase_reg <= rtnp_pkg::PH_OCT)
        begin
            octave_next = (oct_sum > 8'd15) ? 4'd15 : oct_sum[3:0];
            phase_next  = rtnp_pkg::PH_OCT;
        end
        else
        begin
            // drop spaces, stray bytes and misplaced marks
        end

        // end mark flushes a pending note after the character itself
        if (end_of_tune && phase_next >= rtnp_pkg::PH_LETTER)
            fire = 1'b1;
    end

    // Resolve defaults on the post-character state
    always_comb
    begin
        div_pick = (len_div_next != '0) ? len_div_next : 8'(default_length_div);
        note.code    = code_next;
        note.sharp   = sharp_next;
        note.dot     = dot_next;
        note.octave  = (phase_next >= rtnp_pkg::PH_OCT) ? octave_next : default_octave_num;
        note.divisor = (div_pick == '0) ? 8'd1 : div_pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rtnp_pkg::PH_IDLE;
            accum_reg   <= '0;
            code_reg    <= '0;
            sharp_reg   <= 1'b0;
            dot_reg     <= 1'b0;
            len_div_reg <= '0;
            octave_reg  <= '0;
        end
        else if (take)
        begin
            if (fire || drop || end_of_tune)
            begin
                phase_reg   <= rtnp_pkg::PH_IDLE;
                accum_reg   <= '0;
                code_reg    <= '0;
                sharp_reg   <= 1'b0;
                dot_reg     <= 1'b0;
                len_div_reg <= '0;
                octave_reg  <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                accum_reg   <= accum_next;
                code_reg    <= code_next;
                sharp_reg   <= sharp_next;
                dot_reg     <= dot_next;
                len_div_reg <= len_div_next;
                octave_reg  <= octave_next;
            end
        end
    end

endmodule

@@ hdl/rtnp_divider.sv @@
// rtnp_divider: restoring divider, one quotient bit per cycle.
// Depends on rtnp_pkg.
`timescale 1ns / 1ps

module rtnp_divider
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [rtnp_pkg::WHOLE_W-1:0]        dividend,
    input  logic [rtnp_pkg::DIV_W-1:0]          divisor,
    output logic                                done,
    output logic [rtnp_pkg::WHOLE_W-1:0]        quotient
);

    logic                                busy_reg,  busy_next;
    logic [rtnp_pkg::STEP_CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [rtnp_pkg::DIV_W-1:0]          rem_reg,   rem_next;
    logic [rtnp_pkg::WHOLE_W-1:0]        quo_reg,   quo_next;
    logic [rtnp_pkg::DIV_W-1:0]          dsr_reg,   dsr_next;
    logic                                done_reg,  done_next;

    logic [rtnp_pkg::DIV_W:0]            shifted;
    logic [rtnp_pkg::DIV_W:0]            trial;
    logic                                fits;

    assign shifted = {rem_reg, quo_reg[rtnp_pkg::WHOLE_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[rtnp_pkg::DIV_W-1:0] : shifted[rtnp_pkg::DIV_W-1:0];
            quo_next = {quo_reg[rtnp_pkg::WHOLE_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rtnp_pkg::STEP_CNT_W'(rtnp_pkg::DIV_STEPS - 1))
                busy_next = 1'b0;
        end
        // quotient register holds the full result the cycle after the last step
        done_next = busy_reg && !busy_next && !start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ hdl/rtttl_note_parser.sv @@
// rtttl_note_parser: top level; config registers, parser, length divider and note sequencer.
// Depends on rtnp_pkg, rtnp_char_if, rtnp_note_if, rtnp_parser, rtnp_divider.
//
//   port       dir  kind        contents
//   char_in    in   valid/ready char_code, end_of_tune
//   note_out   out  valid/ready frequency_hz, length_ms, rest_flag, octave_used
//   cfg_*      in   write only  cfg_we, cfg_index, cfg_data
//
// A character that completes no note does not stall the input. A character that ends a
// note is taken, then its length is divided bit-serially, the divider raises its done
// flag, and the sequencer adds the dot extension, shifts the frequency and loads the
// result register; the next character is taken only after that.
// No clearing pass after reset; characters are taken as soon as reset is released.
// A waiting result stalls the block only once the next note is ready to be loaded.
`timescale 1ns / 1ps

module rtttl_note_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    rtnp_char_if.sink                           char_in,
    rtnp_note_if.source                         note_out,
    input  logic                                cfg_we,
    input  logic [rtnp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtnp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [rtnp_pkg::DEF_DIV_W-1:0]  def_div_reg;
    logic [rtnp_pkg::OCT_W-1:0]      def_oct_reg;
    logic [rtnp_pkg::WHOLE_W-1:0]    whole_reg;

    rtnp_pkg::seq_state_t            state_reg, state_next;
    rtnp_pkg::note_req_t             note_reg,  note_next;
    rtnp_pkg::note_req_t             parsed;
    logic                            fire;
    logic                            take;
    logic                            div_start;
    logic                            div_done;
    logic [rtnp_pkg::WHOLE_W-1:0]    quotient;

    logic                            out_valid_reg, out_valid_next;
    logic [rtnp_pkg::FREQ_W-1:0]     freq_reg,  freq_next;
    logic [rtnp_pkg::LEN_W-1:0]      len_reg,   len_next;
    logic                            rest_reg,  rest_next;
    logic [rtnp_pkg::OCT_W-1:0]      oct_reg,   oct_next;

    logic [rtnp_pkg::HZ_W-1:0]       hz;
    logic [rtnp_pkg::HZ_W+14:0]      hz_up;
    logic [rtnp_pkg::FREQ_W-1:0]     freq_calc;
    logic                            slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_div_reg <= rtnp_pkg::DEFAULT_LENGTH_DIV_RST;
            def_oct_reg <= rtnp_pkg::DEFAULT_OCTAVE_NUM_RST;
            whole_reg   <= rtnp_pkg::WHOLE_NOTE_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtnp_pkg::CFG_DEFAULT_LENGTH_DIV: def_div_reg <= cfg_data[rtnp_pkg::DEF_DIV_W-1:0];
                rtnp_pkg::CFG_DEFAULT_OCTAVE_NUM: def_oct_reg <= cfg_data[rtnp_pkg::OCT_W-1:0];
                rtnp_pkg::CFG_WHOLE_NOTE_MS:      whole_reg   <= cfg_data[rtnp_pkg::WHOLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign char_in.ready = (state_reg == rtnp_pkg::SEQ_IDLE);
    assign take          = char_in.valid && char_in.ready;

    rtnp_parser u_parser
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .take               (take),
        .char_code          (char_in.char_code),
        .end_of_tune        (char_in.end_of_tune),
        .default_length_div (def_div_reg),
        .default_octave_num (def_oct_reg),
        .fire               (fire),
        .note               (parsed)
    );

    assign div_start = take && fire;

    rtnp_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (whole_reg),
        .divisor  (parsed.divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign slot_free = !out_valid_reg || note_out.ready;

    // Frequency: base-octave value shifted by the octave distance, saturated
    always_comb
    begin
        hz    = rtnp_pkg::note_hz(note_reg.code, note_reg.sharp);
        hz_up = '0;
        if (note_reg.octave >= rtnp_pkg::OCT_W'(rtnp_pkg::BASE_OCTAVE))
        begin
            hz_up = (rtnp_pkg::HZ_W + 15)'(hz)
                    << (note_reg.octave - rtnp_pkg::OCT_W'(rtnp_pkg::BASE_OCTAVE));
            freq_calc = (hz_up > (rtnp_pkg::HZ_W + 15)'(16'hFFFF)) ? 16'hFFFF
                        : hz_up[rtnp_pkg::FREQ_W-1:0];
        end
        else
        begin
            freq_calc = rtnp_pkg::FREQ_W'(hz >> (rtnp_pkg::OCT_W'(rtnp_pkg::BASE_OCTAVE)
                                                 - note_reg.octave));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        note_next      = note_reg;
        out_valid_next = out_valid_reg;
        freq_next      = freq_reg;
        len_next       = len_reg;
        rest_next      = rest_reg;
        oct_next       = oct_reg;

        if (out_valid_reg && note_out.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            rtnp_pkg::SEQ_IDLE:
            begin
                if (div_start)
                begin
                    note_next  = parsed;
                    state_next = rtnp_pkg::SEQ_DIV;
                end
            end
            rtnp_pkg::SEQ_DIV:
            begin
                if (div_done)
                    state_next = rtnp_pkg::SEQ_FIN;
            end
            rtnp_pkg::SEQ_FIN:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    freq_next      = freq_calc;
                    len_next       = rtnp_pkg::LEN_W'(quotient)
                                     + (note_reg.dot ? rtnp_pkg::LEN_W'(quotient >> 1)
                                                     : '0);
                    rest_next      = (note_reg.code == 3'(rtnp_pkg::NOTE_P));
                    oct_next       = note_reg.octave;
                    state_next     = rtnp_pkg::SEQ_IDLE;
                end
            end
            default: state_next = rtnp_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtnp_pkg::SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        freq_reg <= freq_next;
        len_reg  <= len_next;
        rest_reg <= rest_next;
        oct_reg  <= oct_next;
    end

    assign note_out.valid        = out_valid_reg;
    assign note_out.frequency_hz = freq_reg;
    assign note_out.length_ms    = len_reg;
    assign note_out.rest_flag    = rest_reg;
    assign note_out.octave_used  = oct_reg;

endmodule
